FILE: design/lac_pkg.sv
package lac_pkg;

	localparam int LAG_W  = 7;
	localparam int CORR_W = 16;
	localparam int STAT_W = 2;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FEW     = 2'd1;
	localparam logic [STAT_W-1:0] ST_ZVAR    = 2'd2;
	localparam logic [STAT_W-1:0] ST_DROPPED = 2'd3;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_LAGI   = 9'b000000010,
		S_DOT    = 9'b000000100,
		S_REWIND = 9'b000001000,
		S_VMUL   = 9'b000010000,
		S_RT     = 9'b000100000,
		S_WMUL   = 9'b001000000,
		S_EMIT   = 9'b010000000,
		S_FEW    = 9'b100000000
	} state_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

FILE: design/lac_cell.sv
module lac_cell #(
	parameter int W = 16
) (
	input  logic                clk,
	input  lac_pkg::cell_ctl_t  ctl,
	input  logic signed [W-1:0] load_val,
	input  logic signed [W-1:0] prev_val,
	output logic signed [W-1:0] val
);
	import lac_pkg::*;

	logic signed [W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_q <= load_val;
		end else if (ctl.shift) begin
			val_q <= prev_val;
		end
	end

	assign val = val_q;
endmodule

FILE: design/lagged_autocorrelation.sv
// Channel | Signals                                        | Direction
// input   | start, busy, sample, final_sample              | in (busy out)
// result  | strobe, lag, correlation, status, final_result | out
// A non-final sample beat is taken and busy stays low. A series of three or fewer samples
// gives its result beat from the S_FEW state. Otherwise each lag steps the rotating row,
// forms m products, rewinds by k places, computes the variances, forms the wide products
// and runs the root search, then issues the beat; a zero-variance lag skips the wide
// products and the root search.
// Reset clears control, counts, flags and outputs, not the cell rows; the receiver cannot stall.
module lagged_autocorrelation #(
	parameter int MAX_SAMPLES = 128,
	parameter int SAMPLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic signed [15:0] sample,
	input  logic        final_sample,
	output logic        strobe,
	output logic [lac_pkg::LAG_W-1:0]         lag,
	output logic signed [lac_pkg::CORR_W-1:0] correlation,
	output logic [lac_pkg::STAT_W-1:0]        status,
	output logic        final_result
);
	import lac_pkg::*;

	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	localparam int SW  = SAMPLE_BITS + CW;
	localparam int QW  = 2 * SAMPLE_BITS + CW;
	localparam int VW  = 2 * SAMPLE_BITS + 2 * CW + 1;
	localparam int UW  = VW - 1;
	localparam int NCH = (UW + 15) / 16;
	localparam int PW  = 16 * NCH;
	localparam int DW  = 2 * UW;
	localparam int TW  = DW + 36;

	state_t state_q;
	logic [CW-1:0] count_q, n_q, k_q, m_q, i_q;
	logic dropped_q;
	logic signed [SW-1:0] sa_q, sb_q;
	logic signed [QW:0] saa_q, sbb_q, sab_q;
	logic signed [VW-1:0] va_q, vb_q, num_q;
	logic [UW-1:0] ma_q, mn_q;
	logic [PW-1:0] mb_q, mnb_q;
	logic [DW-1:0] d_q, n2_q;
	logic signed [TW-1:0] a_q, bs_q, ds_q;
	logic [15:0] r_q;
	logic [4:0] bit_q;
	logic [2:0] ph_q;
	logic signed [SAMPLE_BITS-1:0] x;
	logic signed [SAMPLE_BITS-1:0] ring_a [MAX_SAMPLES];
	logic signed [SAMPLE_BITS-1:0] ring_b [MAX_SAMPLES];
	logic shift_a, shift_b;
	logic accept;

	assign x = SAMPLE_BITS'(sample[15:0]);
	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);

	// Two rows of cells, each closed into a ring of length n: row a walks the leading
	// segment, row b runs k places ahead of it and walks the trailing segment.
	genvar g;
	generate
		for (g = 0; g < MAX_SAMPLES; g++) begin : g_cell
			cell_ctl_t ca, cb;
			logic signed [SAMPLE_BITS-1:0] na, nb;
			assign ca.load = accept && (count_q == CW'(g));
			assign cb.load = ca.load;
			assign ca.shift = shift_a;
			assign cb.shift = shift_b;
			assign na = (n_q == CW'(g + 1)) ? ring_a[0] : ring_a[(g + 1) % MAX_SAMPLES];
			assign nb = (n_q == CW'(g + 1)) ? ring_b[0] : ring_b[(g + 1) % MAX_SAMPLES];
			lac_cell #(.W(SAMPLE_BITS)) u_cell_a (
				.clk(clk), .ctl(ca), .load_val(x), .prev_val(na), .val(ring_a[g])
			);
			lac_cell #(.W(SAMPLE_BITS)) u_cell_b (
				.clk(clk), .ctl(cb), .load_val(x), .prev_val(nb), .val(ring_b[g])
			);
		end
	endgenerate

	logic signed [SAMPLE_BITS-1:0] a_v, b_v;
	logic signed [2*SAMPLE_BITS-1:0] pab, paa, pbb;
	assign a_v = ring_a[0];
	assign b_v = ring_b[0];
	assign pab = a_v * b_v;
	assign paa = a_v * a_v;
	assign pbb = b_v * b_v;

	assign shift_a = (state_q == S_DOT) || (state_q == S_REWIND);
	assign shift_b = shift_a || (state_q == S_LAGI);

	logic signed [CW:0] m_s;
	logic signed [QW:0] lin_b;
	logic signed [SW-1:0] sq_a, sq_b;
	logic signed [CW+QW+1:0] lin_p;
	logic signed [2*SW-1:0] sq_p;
	logic signed [VW-1:0] vdiff, mag_v;
	assign m_s = $signed({1'b0, m_q});
	assign lin_p = m_s * lin_b;
	assign sq_p = sq_a * sq_b;
	assign vdiff = VW'(lin_p) - VW'(sq_p);
	assign mag_v = num_q[VW-1] ? -num_q : num_q;

	always_comb begin
		lin_b = saa_q;
		sq_a = sa_q;
		sq_b = sa_q;
		case (ph_q)
			3'd1: begin
				lin_b = sbb_q; sq_a = sb_q; sq_b = sb_q;
			end
			3'd2: begin
				lin_b = sab_q; sq_a = sa_q; sq_b = sb_q;
			end
			default: ;
		endcase
	end

	logic [UW+15:0] dpart, npart;
	logic signed [TW-1:0] t_v, rhs_v;
	assign dpart = ma_q * mb_q[PW-1 -: 16];
	assign npart = mn_q * mnb_q[PW-1 -: 16];
	assign t_v = a_q + bs_q + ds_q;
	assign rhs_v = $signed({{(TW-DW-32){1'b0}}, n2_q, 32'd0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0; n_q <= '0; k_q <= '0; m_q <= '0; i_q <= '0;
			dropped_q <= 1'b0;
			sa_q <= '0; sb_q <= '0; saa_q <= '0; sbb_q <= '0; sab_q <= '0;
			va_q <= '0; vb_q <= '0; num_q <= '0;
			ma_q <= '0; mb_q <= '0; mn_q <= '0; mnb_q <= '0; d_q <= '0; n2_q <= '0;
			a_q <= '0; bs_q <= '0; ds_q <= '0;
			r_q <= '0; bit_q <= '0; ph_q <= '0;
			strobe <= 1'b0;
			lag <= '0; correlation <= '0; status <= ST_OK; final_result <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (count_q < CW'(MAX_SAMPLES)) count_q <= count_q + 1'b1;
						else dropped_q <= 1'b1;
						if (final_sample) begin
							n_q <= (count_q < CW'(MAX_SAMPLES)) ? count_q + 1'b1 : count_q;
							k_q <= CW'(1);
							if (count_q < CW'(3)) state_q <= S_FEW;
							else state_q <= S_LAGI;
						end
					end
				end
				S_FEW: begin
					strobe <= 1'b1;
					lag <= '0; correlation <= '0; status <= ST_FEW; final_result <= 1'b1;
					count_q <= '0; dropped_q <= 1'b0;
					state_q <= S_IDLE;
				end
				S_LAGI: begin
					i_q <= '0;
					m_q <= n_q - k_q;
					sab_q <= '0; sa_q <= '0; sb_q <= '0; saa_q <= '0; sbb_q <= '0;
					state_q <= S_DOT;
				end
				S_DOT: begin
					sab_q <= sab_q + (QW+1)'(pab);
					sa_q <= sa_q + SW'(a_v);
					sb_q <= sb_q + SW'(b_v);
					saa_q <= saa_q + (QW+1)'(paa);
					sbb_q <= sbb_q + (QW+1)'(pbb);
					i_q <= i_q + 1'b1;
					if (i_q + 1'b1 == m_q) begin
						state_q <= S_REWIND;
						i_q <= '0;
					end
				end
				S_REWIND: begin
					i_q <= i_q + 1'b1;
					if (i_q + 1'b1 == k_q) begin
						ph_q <= '0;
						state_q <= S_VMUL;
					end
				end
				S_VMUL: begin
					ph_q <= ph_q + 1'b1;
					case (ph_q)
						3'd0: va_q <= vdiff;
						3'd1: vb_q <= vdiff;
						3'd2: num_q <= vdiff;
						default: begin
							if (va_q <= 0 || vb_q <= 0) begin
								state_q <= S_EMIT;
							end else begin
								ma_q <= va_q[UW-1:0];
								mb_q <= PW'(vb_q[UW-1:0]);
								mn_q <= mag_v[UW-1:0];
								mnb_q <= PW'(mag_v[UW-1:0]);
								d_q <= '0;
								n2_q <= '0;
								ph_q <= '0;
								state_q <= S_WMUL;
							end
						end
					endcase
				end
				S_WMUL: begin
					if (ph_q < 3'(NCH)) begin
						d_q <= (d_q << 16) + DW'(dpart);
						n2_q <= (n2_q << 16) + DW'(npart);
						mb_q <= mb_q << 16;
						mnb_q <= mnb_q << 16;
						ph_q <= ph_q + 1'b1;
					end else begin
						a_q <= TW'(d_q);
						bs_q <= '0 - (TW'(d_q) << 17);
						ds_q <= TW'(d_q) << 32;
						r_q <= '0;
						bit_q <= 5'd15;
						state_q <= S_RT;
					end
				end
				S_RT: begin
					// One result bit per cycle, MSB first, on running multiples of the product.
					if (t_v <= rhs_v) begin
						a_q <= t_v;
						r_q <= r_q | (16'd1 << bit_q[3:0]);
						bs_q <= (bs_q >>> 1) + ds_q;
					end else begin
						bs_q <= bs_q >>> 1;
					end
					ds_q <= ds_q >>> 2;
					if (bit_q == 5'd0) state_q <= S_EMIT;
					else bit_q <= bit_q - 1'b1;
				end
				S_EMIT: begin
					strobe <= 1'b1;
					lag <= LAG_W'(k_q);
					final_result <= (k_q == (n_q >> 1));
					if (va_q <= 0 || vb_q <= 0) begin
						status <= ST_ZVAR; correlation <= '0;
					end else begin
						status <= dropped_q ? ST_DROPPED : ST_OK;
						if (num_q < 0) correlation <= CORR_W'(-$signed({1'b0, r_q}));
						else correlation <= r_q[15] ? 16'sd32767 : $signed({1'b0, r_q[14:0]});
					end
					if (k_q == (n_q >> 1)) begin
						count_q <= '0; dropped_q <= 1'b0; state_q <= S_IDLE;
					end else begin
						k_q <= k_q + 1'b1; state_q <= S_LAGI;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	property p_strobe_busy;
		@(posedge clk) disable iff (!arst_n) strobe |-> $past(busy);
	endproperty
	a_strobe_busy: assert property (p_strobe_busy) else $error("result while idle");

	property p_idle_after_final;
		@(posedge clk) disable iff (!arst_n) (strobe && final_result) |-> !busy;
	endproperty
	a_idle_after_final: assert property (p_idle_after_final) else $error("busy after last");

	property p_lag_range;
		@(posedge clk) disable iff (!arst_n) strobe |-> (lag <= LAG_W'(MAX_SAMPLES / 2));
	endproperty
	a_lag_range: assert property (p_lag_range) else $error("lag out of range");

endmodule

FILE: verif/tb_lagged_autocorrelation.sv
`timescale 1ns / 1ps

module tb_lagged_autocorrelation;
	import lac_pkg::*;

	typedef struct {
		logic signed [15:0] value;
		logic               last;
		bit                 hold;
	} beat_t;

	typedef struct {
		logic [LAG_W-1:0]         lag;
		logic signed [CORR_W-1:0] corr;
		logic [STAT_W-1:0]        status;
		logic                     last;
	} corr_result_t;

	localparam int CAP = 128;
	localparam int CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [15:0] sample = '0;
	logic final_sample = 1'b0;
	logic busy;
	logic strobe;
	logic [LAG_W-1:0] lag;
	logic signed [CORR_W-1:0] correlation;
	logic [STAT_W-1:0] status;
	logic final_result;

	beat_t pending_beats[$];
	corr_result_t expected_corr[$];
	int mismatches = 0;
	int gap = 0;
	int cycles = 0;
	bit stim_done = 0;

	longint series_val[CAP];
	longint run_sum[CAP+1];
	longint run_sq[CAP+1];
	int series_len = 0;
	bit series_dropped = 0;

	lagged_autocorrelation uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample(sample), .final_sample(final_sample), .strobe(strobe),
		.lag(lag), .correlation(correlation), .status(status),
		.final_result(final_result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int q15_ratio(longint unsigned mag, longint unsigned va,
			longint unsigned vb);
		logic [255:0] den;
		logic [255:0] rhs;
		logic [255:0] odd;
		int lo;
		int hi;
		int mid;
		den = 256'(va) * 256'(vb);
		rhs = (256'(mag) * 256'(mag)) << 32;
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			odd = 256'(2 * mid - 1);
			if (odd * odd * den <= rhs) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		return lo;
	endfunction

	task automatic absorb_sample(beat_t b);
		longint x;
		longint sab;
		longint va;
		longint vb;
		longint num;
		longint sa;
		longint sb;
		int m;
		int rr;
		corr_result_t r;
		x = b.value;
		if (series_len < CAP) begin
			series_val[series_len] = x;
			run_sum[series_len+1] = run_sum[series_len] + x;
			run_sq[series_len+1] = run_sq[series_len] + x * x;
			series_len++;
		end else begin
			series_dropped = 1;
		end
		if (!b.last) return;
		if (series_len <= 3) begin
			r.lag = '0; r.corr = '0; r.status = ST_FEW; r.last = 1'b1;
			expected_corr.push_back(r);
		end else begin
			for (int k = 1; k <= series_len / 2; k++) begin
				m = series_len - k;
				sa = run_sum[m];
				sb = run_sum[series_len] - run_sum[k];
				sab = 0;
				for (int i = 0; i < m; i++) sab += series_val[i] * series_val[i+k];
				va = m * run_sq[m] - sa * sa;
				vb = m * (run_sq[series_len] - run_sq[k]) - sb * sb;
				num = m * sab - sa * sb;
				r.lag = LAG_W'(k);
				r.last = (k == series_len / 2);
				if (va <= 0 || vb <= 0) begin
					r.corr = '0;
					r.status = ST_ZVAR;
				end else begin
					rr = q15_ratio((num < 0) ? -num : num, va, vb);
					if (num < 0) r.corr = CORR_W'(-rr);
					else r.corr = (rr > 32767) ? 16'sd32767 : CORR_W'(rr);
					r.status = series_dropped ? ST_DROPPED : ST_OK;
				end
				expected_corr.push_back(r);
			end
		end
		series_len = 0;
		series_dropped = 0;
	endtask

	task automatic queue_series(int len, int kind, bit hold);
		beat_t b;
		logic signed [15:0] base;
		base = 16'($urandom);
		for (int i = 0; i < len; i++) begin
			case (kind)
				0: b.value = 16'($urandom);
				1: b.value = base;
				2: b.value = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
				default: b.value = 16'($signed($urandom_range(0, 6)) - 3);
			endcase
			b.last = (i == len - 1);
			b.hold = hold && (i == 0);
			pending_beats.push_back(b);
		end
	endtask

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	always @(posedge clk) begin
		bit drive;
		beat_t nb;
		if (arst_n) begin
			drive = start;
			if (start && !busy) begin
				absorb_sample(pending_beats.pop_front());
				drive = 0;
				gap = pick_gap();
			end
			if (!drive) begin
				if (gap > 0) begin
					gap--;
				end else if (pending_beats.size() > 0 &&
						(!pending_beats[0].hold || expected_corr.size() == 0)) begin
					nb = pending_beats[0];
					sample <= nb.value;
					final_sample <= nb.last;
					drive = 1;
				end
			end
			start <= drive;
		end
	end

	always @(posedge clk) begin
		corr_result_t e;
		if (strobe) begin
			if (expected_corr.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result lag=%0d corr=%0d status=%0d last=%0b",
						lag, correlation, status, final_result);
			end else begin
				e = expected_corr.pop_front();
				if (e.lag !== lag || e.corr !== correlation || e.status !== status ||
						e.last !== final_result) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp lag=%0d corr=%0d st=%0d last=%0b %s",
							e.lag, e.corr, e.status, e.last, "got:");
					if (mismatches <= 10)
						$display("  lag=%0d corr=%0d st=%0d last=%0b",
							lag, correlation, status, final_result);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int total;
		int len;
		beat_t b;
		for (int i = 0; i <= CAP; i++) begin
			run_sum[i] = 0;
			run_sq[i] = 0;
		end
		b.hold = 0;
		b.value = 16'sh7fff; b.last = 1; pending_beats.push_back(b);
		queue_series(3, 0, 0);
		queue_series(4, 1, 1);
		b.value = 16'sh8000; b.last = 0; pending_beats.push_back(b);
		b.value = 16'sh7fff; pending_beats.push_back(b);
		b.value = 16'sh0000; pending_beats.push_back(b);
		b.value = 16'shffff; pending_beats.push_back(b);
		b.value = 16'sh8000; b.last = 1; pending_beats.push_back(b);
		queue_series(6, 2, 0);
		queue_series(5, 3, 0);
		total = pending_beats.size();
		queue_series(130, 0, 1);
		queue_series(128, 3, 0);
		total += 258;
		while (total < 360) begin
			case ($urandom_range(0, 9))
				0: len = $urandom_range(1, 3);
				1: len = $urandom_range(4, 40);
				default: len = $urandom_range(4, 14);
			endcase
			queue_series(len, ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3),
				$urandom_range(0, 7) == 0);
			total += len;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_beats.size() == 0);
		wait (expected_corr.size() == 0);
		repeat (400) @(posedge clk);
		if (mismatches == 0 && expected_corr.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
